@@ rtl/core/idea_pkg.sv @@
// Shared constants, types and modular arithmetic helpers for the IDEA encryptor.
`default_nettype none
package idea_pkg;
   localparam int ROUND_COUNT_DEF = 8;
   localparam int KEY_DEPTH       = 52;
   localparam int KEYS_PER_ROUND  = 6;
   localparam int CELL_STAGES     = 6;
   localparam logic [17:0] MUL_MODULUS = 18'h10001;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_ENCRYPT = 1'b1;

   typedef logic [3:0][15:0] blk_type;

   // Map word 0 onto 65536.
   function automatic logic [16:0] widen(logic [15:0] w);
      return (w == 16'd0) ? 17'h10000 : {1'b0, w};
   endfunction

   // Full product of two operands in 1..65536.
   function automatic logic [32:0] mul_full(logic [15:0] a, logic [15:0] b);
      return {16'd0, widen(a)} * {16'd0, widen(b)};
   endfunction

   // Reduce a product modulo 65537: low half minus high half, fold once.
   function automatic logic [15:0] mul_reduce(logic [32:0] p);
      logic [17:0] diff;
      diff = {2'b00, p[15:0]} - {1'b0, p[32:16]};
      if (diff[17]) begin
         diff = diff + MUL_MODULUS;
      end
      return diff[15:0];
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/idea_round_cell.sv @@
// One IDEA round as a six-stage pipeline cell.
`default_nettype none
module idea_round_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic [5:0][15:0]      key,
   input  wire logic                  in_valid,
   input  wire idea_pkg::blk_type     in_blk,
   output logic                       out_valid,
   output idea_pkg::blk_type          out_blk
);
   logic [5:0]  v_ff;
   logic [32:0] pa_ff, pd_ff, pe_ff, pf_ff;
   logic [15:0] b1_ff, c1_ff;
   logic [15:0] a2_ff, b2_ff, c2_ff, d2_ff, e2_ff, f2_ff;
   logic [15:0] a3_ff, b3_ff, c3_ff, d3_ff, f3_ff;
   logic [15:0] a4_ff, b4_ff, c4_ff, d4_ff, e4_ff, f4_ff;
   logic [15:0] a5_ff, b5_ff, c5_ff, d5_ff, e5_ff;
   idea_pkg::blk_type out_ff;
   logic [15:0] a2_in, d2_in, e4_in, f6_in, e6_in;

   assign a2_in = idea_pkg::mul_reduce(pa_ff);
   assign d2_in = idea_pkg::mul_reduce(pd_ff);
   assign e4_in = idea_pkg::mul_reduce(pe_ff);
   assign f6_in = idea_pkg::mul_reduce(pf_ff);
   assign e6_in = e5_ff + f6_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff <= idea_pkg::mul_full(in_blk[0], key[0]);
         b1_ff <= in_blk[1] + key[1];
         c1_ff <= in_blk[2] + key[2];
         pd_ff <= idea_pkg::mul_full(in_blk[3], key[3]);
         a2_ff <= a2_in;
         b2_ff <= b1_ff;
         c2_ff <= c1_ff;
         d2_ff <= d2_in;
         e2_ff <= a2_in ^ c1_ff;
         f2_ff <= b1_ff ^ d2_in;
         pe_ff <= idea_pkg::mul_full(e2_ff, key[4]);
         a3_ff <= a2_ff;
         b3_ff <= b2_ff;
         c3_ff <= c2_ff;
         d3_ff <= d2_ff;
         f3_ff <= f2_ff;
         e4_ff <= e4_in;
         f4_ff <= f3_ff + e4_in;
         a4_ff <= a3_ff;
         b4_ff <= b3_ff;
         c4_ff <= c3_ff;
         d4_ff <= d3_ff;
         pf_ff <= idea_pkg::mul_full(f4_ff, key[5]);
         e5_ff <= e4_ff;
         a5_ff <= a4_ff;
         b5_ff <= b4_ff;
         c5_ff <= c4_ff;
         d5_ff <= d4_ff;
         // mix and swap the middle words
         out_ff[0] <= a5_ff ^ f6_in;
         out_ff[1] <= c5_ff ^ f6_in;
         out_ff[2] <= b5_ff ^ e6_in;
         out_ff[3] <= d5_ff ^ e6_in;
      end
   end

   assign out_valid = v_ff[5];
   assign out_blk   = out_ff;
endmodule
`default_nettype wire

@@ rtl/core/idea_out_cell.sv @@
// Output transform of IDEA as a two-stage cell; its last stage is the result register.
`default_nettype none
module idea_out_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic [3:0][15:0]      key,
   input  wire logic                  in_valid,
   input  wire idea_pkg::blk_type     in_blk,
   output logic                       out_valid,
   output idea_pkg::blk_type          out_blk
);
   logic [1:0]  v_ff;
   logic [32:0] p0_ff, p3_ff;
   logic [15:0] w1_ff, w2_ff;
   idea_pkg::blk_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff     <= idea_pkg::mul_full(in_blk[0], key[0]);
         w1_ff     <= in_blk[2] + key[1];
         w2_ff     <= in_blk[1] + key[2];
         p3_ff     <= idea_pkg::mul_full(in_blk[3], key[3]);
         out_ff[0] <= idea_pkg::mul_reduce(p0_ff);
         out_ff[1] <= w1_ff;
         out_ff[2] <= w2_ff;
         out_ff[3] <= idea_pkg::mul_reduce(p3_ff);
      end
   end

   assign out_valid = v_ff[1];
   assign out_blk   = out_ff;
endmodule
`default_nettype wire

@@ rtl/core/idea_block_encrypt_top.sv @@
// Top level of the pipelined IDEA block encryptor.
// Usage:
//  - req channel: one word per accepted cycle (req_valid high, req_stall low).
//    req_mode = load writes req_subkey_value into subkey slot req_subkey_index
//    (slots above 51 are dropped); req_mode = encrypt sends in_word0..3 in.
//  - rsp channel: one word of four ciphertext words per encrypt word, in order;
//    load words give no response.
//  - Throughput one block per cycle while no valid response is stalled, set
//    by the chain of round cells, each a six-stage pipeline with its
//    multiply/reduce steps on subkeys 0, 3, 4 and 5.
//  - A load word waits (req_stall high) until every block in flight has left,
//    so subkeys never change under a block; all 52 slots used must be loaded
//    before encrypting.
//  - When the receiver stalls a valid response the whole chain holds, and
//    req_stall follows so nothing is dropped.
//  - Reset clears the pipeline valids and the in-flight count; the subkey
//    table keeps no reset value.
`default_nettype none
module idea_block_encrypt_top #(
   parameter int ROUND_COUNT = idea_pkg::ROUND_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [5:0]  req_subkey_index,
   input  wire logic [15:0] req_subkey_value,
   input  wire logic [15:0] req_in_word0,
   input  wire logic [15:0] req_in_word1,
   input  wire logic [15:0] req_in_word2,
   input  wire logic [15:0] req_in_word3,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_out_word0,
   output logic [15:0]      rsp_out_word1,
   output logic [15:0]      rsp_out_word2,
   output logic [15:0]      rsp_out_word3
);
   localparam int LATENCY = idea_pkg::CELL_STAGES * ROUND_COUNT + 2;
   localparam int CNT_W   = $clog2(LATENCY + 1);
   localparam int OUT_KEY = idea_pkg::KEYS_PER_ROUND * ROUND_COUNT;

   logic [15:0]      key_ff [idea_pkg::KEY_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             adv, req_take, enc_take, load_take, rsp_take;

   logic              valid_chain [ROUND_COUNT+1];
   idea_pkg::blk_type blk_chain   [ROUND_COUNT+1];
   logic [3:0][15:0]  out_key;
   idea_pkg::blk_type rsp_blk;

   // Hold the whole chain while a finished result waits.
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv || (req_mode == idea_pkg::MODE_LOAD && count_ff != '0);
   assign req_take  = req_valid && !req_stall;
   assign enc_take  = req_take && req_mode == idea_pkg::MODE_ENCRYPT;
   assign load_take = req_take && req_mode == idea_pkg::MODE_LOAD;
   assign rsp_take  = rsp_valid && !rsp_stall;

   // Track blocks in flight so loads only land on an empty chain.
   always_comb begin
      count_in = count_ff;
      if (enc_take && !rsp_take) begin
         count_in = count_ff + 1'b1;
      end else if (!enc_take && rsp_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Subkey table: written by load words, read at fixed slots by each cell.
   always_ff @(posedge clock) begin
      if (load_take && req_subkey_index < 6'(idea_pkg::KEY_DEPTH)) begin
         key_ff[req_subkey_index] <= req_subkey_value;
      end
   end

   assign valid_chain[0] = enc_take;
   assign blk_chain[0]   = {req_in_word3, req_in_word2, req_in_word1, req_in_word0};

   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      logic [5:0][15:0] cell_key;
      for (genvar j = 0; j < idea_pkg::KEYS_PER_ROUND; j++) begin : g_key
         assign cell_key[j] = key_ff[idea_pkg::KEYS_PER_ROUND * r + j];
      end
      idea_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .key       (cell_key),
         .in_valid  (valid_chain[r]),
         .in_blk    (blk_chain[r]),
         .out_valid (valid_chain[r+1]),
         .out_blk   (blk_chain[r+1])
      );
   end

   for (genvar j = 0; j < 4; j++) begin : g_out_key
      assign out_key[j] = key_ff[OUT_KEY + j];
   end

   idea_out_cell u_out (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .key       (out_key),
      .in_valid  (valid_chain[ROUND_COUNT]),
      .in_blk    (blk_chain[ROUND_COUNT]),
      .out_valid (rsp_valid),
      .out_blk   (rsp_blk)
   );

   assign rsp_out_word0 = rsp_blk[0];
   assign rsp_out_word1 = rsp_blk[1];
   assign rsp_out_word2 = rsp_blk[2];
   assign rsp_out_word3 = rsp_blk[3];
endmodule
`default_nettype wire

@@ test/idea_block_encrypt_top_test.sv @@
// Self-checking testbench for the pipelined IDEA block encryptor.
`default_nettype none
module idea_block_encrypt_top_test;

   localparam int N_ROUNDS  = idea_pkg::ROUND_COUNT_DEF;
   localparam int N_ITEMS   = 1850;
   localparam int LATENCY   = 6 * N_ROUNDS + 2;
   localparam int MAX_CYCLE = 400000;

   // Expected ciphertext block.
   typedef struct packed {
      logic [15:0] w0, w1, w2, w3;
   } cipher_type;

   // Tracks the subkey table and predicts ciphertext for each accepted block.
   class scoreboard_type;
      logic [15:0] subkeys [idea_pkg::KEY_DEPTH];
      cipher_type  pending [$];
      int          errors;
      int          blocks_checked;
      int          loads_seen;

      function logic [15:0] gf_mul(logic [15:0] a, logic [15:0] b);
         longint unsigned x, y;
         x = (a == 0) ? 65536 : a;
         y = (b == 0) ? 65536 : b;
         return 16'((x * y) % 65537);
      endfunction

      function void note_word(logic mode, logic [5:0] idx, logic [15:0] val,
                              logic [15:0] i0, logic [15:0] i1,
                              logic [15:0] i2, logic [15:0] i3);
         logic [15:0] x0, x1, x2, x3, a, b, c, d, e, f;
         int base;
         cipher_type exp_blk;
         if (mode == idea_pkg::MODE_LOAD) begin
            loads_seen++;
            if (idx < idea_pkg::KEY_DEPTH) subkeys[idx] = val;
            return;
         end
         x0 = i0; x1 = i1; x2 = i2; x3 = i3;
         for (int r = 0; r < N_ROUNDS; r++) begin
            base = idea_pkg::KEYS_PER_ROUND * r;
            a = gf_mul(x0, subkeys[base]);
            b = x1 + subkeys[base + 1];
            c = x2 + subkeys[base + 2];
            d = gf_mul(x3, subkeys[base + 3]);
            e = gf_mul(a ^ c, subkeys[base + 4]);
            f = gf_mul((b ^ d) + e, subkeys[base + 5]);
            e = e + f;
            x0 = a ^ f; x1 = c ^ f; x2 = b ^ e; x3 = d ^ e;
         end
         base = idea_pkg::KEYS_PER_ROUND * N_ROUNDS;
         exp_blk.w0 = gf_mul(x0, subkeys[base]);
         exp_blk.w1 = x2 + subkeys[base + 1];
         exp_blk.w2 = x1 + subkeys[base + 2];
         exp_blk.w3 = gf_mul(x3, subkeys[base + 3]);
         pending.push_back(exp_blk);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_block(cipher_type got);
         cipher_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected block %h", got));
            return;
         end
         want = pending.pop_front();
         if (got.w0 !== want.w0)
            report($sformatf("word0 got %h want %h (block %0d)", got.w0, want.w0,
                             blocks_checked));
         if (got.w1 !== want.w1)
            report($sformatf("word1 got %h want %h (block %0d)", got.w1, want.w1,
                             blocks_checked));
         if (got.w2 !== want.w2)
            report($sformatf("word2 got %h want %h (block %0d)", got.w2, want.w2,
                             blocks_checked));
         if (got.w3 !== want.w3)
            report($sformatf("word3 got %h want %h (block %0d)", got.w3, want.w3,
                             blocks_checked));
         blocks_checked++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = idea_pkg::MODE_LOAD;
   logic [5:0]  req_subkey_index = '0;
   logic [15:0] req_subkey_value = '0;
   logic [15:0] req_in_word0 = '0, req_in_word1 = '0;
   logic [15:0] req_in_word2 = '0, req_in_word3 = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [15:0] rsp_out_word0, rsp_out_word1, rsp_out_word2, rsp_out_word3;

   scoreboard_type board = new();
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  hold_off = 1'b0;      // long receiver hold-off in progress
   int  n_blocks = 0;

   idea_block_encrypt_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Count cycles; give up at a generous limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLE) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function int gap_len();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   // Offer one word and hold it until accepted, then note it on the scoreboard.
   // Valid stays high after acceptance; drop it only when a gap follows.
   task send_word(logic mode, logic [5:0] idx, logic [15:0] val,
                  logic [15:0] i0, logic [15:0] i1,
                  logic [15:0] i2, logic [15:0] i3, bit with_gap);
      int g;
      g = with_gap ? gap_len() : 0;
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_subkey_index <= idx;
      req_subkey_value <= val;
      req_in_word0     <= i0;
      req_in_word1     <= i1;
      req_in_word2     <= i2;
      req_in_word3     <= i3;
      // Wait for the edge where valid is high and stall is low.
      do @(posedge clock); while (req_stall);
      board.note_word(mode, idx, val, i0, i1, i2, i3);
   endtask

   task send_block(logic [15:0] i0, logic [15:0] i1, logic [15:0] i2,
                   logic [15:0] i3, bit with_gap);
      send_word(idea_pkg::MODE_ENCRYPT, 6'($urandom()), 16'($urandom()),
                i0, i1, i2, i3, with_gap);
   endtask

   // Load every subkey slot, random or all from one pattern.
   task load_table(int kind, bit with_gap);
      logic [15:0] v;
      for (int k = 0; k < idea_pkg::KEY_DEPTH; k++) begin
         case (kind)
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'h0001;
            default: v = 16'($urandom());
         endcase
         send_word(idea_pkg::MODE_LOAD, 6'(k), v, 16'($urandom()), 16'($urandom()),
                   16'($urandom()), 16'($urandom()), with_gap);
      end
   endtask

   // Random word: 16-bit value skewed toward the edges.
   function logic [15:0] rnd_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0001;
         default: return 16'($urandom());
      endcase
   endfunction

   // Receiver: random stall with occasional long runs, plus one long hold-off.
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1: rsp_stall <= 1'b1;
            2: begin
               rsp_stall <= 1'b1;
               if ($urandom_range(0, 29) == 0) stall_left <= $urandom_range(10, 60);
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_block({rsp_out_word0, rsp_out_word1,
                            rsp_out_word2, rsp_out_word3});
      end
   end

   // Hold off the receiver for a long stretch once, counted in cycles.
   initial begin
      wait (n_blocks >= 200);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: degenerate tables, extreme plaintexts.
      load_table(0, 1'b0);
      send_block(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_block(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      load_table(1, 1'b1);
      send_block(16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 1'b0);
      send_block(16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 1'b1);
      load_table(2, 1'b0);
      send_block(16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b1);
      // Out-of-range loads must be dropped.
      send_word(idea_pkg::MODE_LOAD, 6'd52, 16'h1234, '0, '0, '0, '0, 1'b1);
      send_word(idea_pkg::MODE_LOAD, 6'd63, 16'hBEEF, '1, '1, '1, '1, 1'b1);
      send_block(16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b1);
      n_blocks = 6;

      // Random: fresh key, then bursts of blocks with occasional rekeys.
      // Offer only blocks, no loads, while the receiver is held off.
      load_table(3, 1'b1);
      while (n_blocks + board.loads_seen < N_ITEMS) begin
         case ($urandom_range(0, 39))
            0: begin
               if (!hold_off) begin
                  send_word(idea_pkg::MODE_LOAD, 6'($urandom_range(0, 63)),
                            rnd_word(), 16'($urandom()), 16'($urandom()),
                            16'($urandom()), 16'($urandom()), 1'b1);
               end
            end
            1: begin
               if (!hold_off && $urandom_range(0, 9) == 0) begin
                  load_table(3, 1'b1);
               end
            end
            default: begin
               send_block(rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                          1'($urandom_range(0, 1)));
               n_blocks++;
            end
         endcase
      end
      req_valid <= 1'b0;

      // Drain the pending queue, then linger.
      while (board.pending.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      $display("sent %0d blocks and %0d loads; checked %0d ciphertext blocks",
               n_blocks, board.loads_seen, board.blocks_checked);
      $display("run held all-zero, all-ones and random keys, dropped loads, and a full stall");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ idea_block_encrypt_top.f @@
rtl/core/idea_pkg.sv
rtl/core/idea_round_cell.sv
rtl/core/idea_out_cell.sv
rtl/core/idea_block_encrypt_top.sv
test/idea_block_encrypt_top_test.sv
